FILE: hdl/mbe_pkg.sv
`default_nettype none
package mbe_pkg;

  localparam int FRAC_BITS   = 26;
  localparam int COORD_LIMIT = 4096;

  localparam int IDX_W     = 12;
  localparam int CNT_W     = 16;
  localparam int COLOR_W   = 4;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int C_W    = FRAC_BITS + 3;
  localparam int Z_W    = FRAC_BITS + 4;
  localparam int SQ_W   = FRAC_BITS + 6;
  localparam int XY_W   = FRAC_BITS + 8;
  localparam int PROD_W = IDX_W + 1 + REG_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(64'd1 << (FRAC_BITS + 2));

  localparam int COLOR_MULT = 5;

  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

  localparam logic [REG_W-1:0] X_STEP_RST   = 32'h000E_0000;
  localparam logic [REG_W-1:0] Y_STEP_RST   = 32'h000C_0000;
  localparam logic [REG_W-1:0] X_ORIGIN_RST = 32'hF600_0000;
  localparam logic [REG_W-1:0] Y_ORIGIN_RST = 32'hFA00_0000;
  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd1024;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_row;
    logic [IDX_W-1:0] pixel_column;
  } pixel_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_column;
    logic [CNT_W-1:0]   escape_count;
    logic [COLOR_W-1:0] color_index;
  } result_word_t;

  typedef struct packed {
    logic signed [REG_W-1:0] x_step;
    logic signed [REG_W-1:0] y_step;
    logic signed [REG_W-1:0] x_origin;
    logic signed [REG_W-1:0] y_origin;
    logic [CNT_W-1:0]        max_iterations;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
  } job_t;

  function automatic logic [COLOR_W-1:0] color_of(input logic [CNT_W-1:0] count);
    logic [COLOR_W-1:0] low;
    low = count[COLOR_W-1:0];
    return COLOR_W'(low * COLOR_W'(COLOR_MULT));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mbe_front.sv
`default_nettype none
module mbe_front
  import mbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire pixel_word_t pixel,
  input  wire cfg_t        cfg,
  output logic             job_valid,
  output job_t             job,
  input  wire logic        job_ready
);

  logic                     valid1;
  logic [IDX_W-1:0]         row1;
  logic [IDX_W-1:0]         col1;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;
  logic                     advance;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
    if (32'(idx) >= 32'(COORD_LIMIT)) begin
      return IDX_W'(COORD_LIMIT - 1);
    end
    return idx;
  endfunction

  function automatic logic signed [C_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-C_W:0] top;
    top = v[SUM_W-1:C_W-1];
    if ((&top) || !(|top)) begin
      return v[C_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
  endfunction

  assign advance = !valid1 || job_ready;
  assign full    = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (advance) begin
      valid1 <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && advance) begin
      row1    <= pixel.pixel_row;
      col1    <= pixel.pixel_column;
      prod_re <= $signed({1'b0, clamp_idx(pixel.pixel_column)}) * cfg.x_step;
      prod_im <= $signed({1'b0, clamp_idx(pixel.pixel_row)}) * cfg.y_step;
    end
  end

  assign sum_re = SUM_W'(cfg.x_origin) + SUM_W'(prod_re);
  assign sum_im = SUM_W'(cfg.y_origin) + SUM_W'(prod_im);

  assign job_valid = valid1;
  assign job.row   = row1;
  assign job.col   = col1;
  assign job.c_re  = sat_coord(sum_re);
  assign job.c_im  = sat_coord(sum_im);

endmodule
`default_nettype wire

FILE: hdl/mbe_queue.sv
`default_nettype none
module mbe_queue
  import mbe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t din,
  output logic      full,
  input  wire logic pop,
  output job_t      dout,
  output logic      empty
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW_ = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW_-1:0]  count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW_'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mbe_iter.sv
`default_nettype none
module mbe_iter
  import mbe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  input  wire job_t             job,
  output logic                  job_take,
  input  wire logic [CNT_W-1:0] max_iterations,
  output logic                  result_empty,
  output result_word_t          result,
  input  wire logic             result_pop
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                state;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic signed [C_W-1:0]     c_re;
  logic signed [C_W-1:0]     c_im;
  logic signed [Z_W-1:0]     x;
  logic signed [Z_W-1:0]     y;
  logic [CNT_W-1:0]          count;
  logic [SQ_W-1:0]           sx;
  logic [SQ_W-1:0]           sy;
  logic signed [XY_W-1:0]    sxy;
  logic                      res_valid;
  result_word_t              res;

  logic signed [2*Z_W-1:0]   p_xx;
  logic signed [2*Z_W-1:0]   p_yy;
  logic signed [2*Z_W-1:0]   p_xy;
  logic [SQ_W:0]             sq_sum;
  logic                      escape;
  logic signed [SQ_W+1:0]    nx_full;
  logic signed [XY_W:0]      ny_full;
  logic                      res_free;

  assign p_xx = x * x;
  assign p_yy = y * y;
  assign p_xy = x * y;

  assign sq_sum  = {1'b0, sx} + {1'b0, sy};
  assign escape  = (sq_sum >= ESC_LIMIT);
  assign nx_full = $signed({2'b00, sx}) - $signed({2'b00, sy}) + (SQ_W + 2)'(c_re);
  assign ny_full = (XY_W + 1)'(sxy) + (XY_W + 1)'(c_im);

  assign res_free     = !res_valid || result_pop;
  assign job_take     = (state == ST_IDLE) && job_valid;
  assign result_empty = !res_valid;
  assign result       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= (count >= max_iterations) ? ST_DONE : ST_ADD;
        end
        ST_ADD: begin
          state <= escape ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row   <= job.row;
        col   <= job.col;
        c_re  <= job.c_re;
        c_im  <= job.c_im;
        x     <= '0;
        y     <= '0;
        count <= '0;
      end
      ST_MUL: begin
        sx  <= p_xx[FRAC_BITS+SQ_W-1:FRAC_BITS];
        sy  <= p_yy[FRAC_BITS+SQ_W-1:FRAC_BITS];
        sxy <= p_xy[FRAC_BITS+XY_W-2:FRAC_BITS-1];
      end
      ST_ADD: begin
        if (!escape) begin
          x     <= nx_full[Z_W-1:0];
          y     <= ny_full[Z_W-1:0];
          count <= count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_DONE) && res_free) begin
      res_valid <= 1'b1;
    end else if (result_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && res_free) begin
      res.out_row      <= row;
      res.out_column   <= col;
      res.escape_count <= count;
      res.color_index  <= color_of(count);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mandelbrot_escape_time.sv
// Mandelbrot escape-time engine. Push a pixel word (row, column); the front stage maps it to
// the point c with two multiply-adds and saturates c to [-4, 4), then parks it in a
// QDEPTH-entry queue, so up to QDEPTH + 1 pixels can be taken while the iterator is busy.
// The iterator runs one pixel at a time through a shared set of three multipliers: state MUL
// registers x*x, y*y and x*y, then state ADD tests |z|^2 against 4 and updates z. A pixel
// stops when it escapes or when its count reaches max_iterations, which is 1024 after reset.
// The result word waits in an output register while the iterator starts on the next pixel.
// Fixed point carries 26 fraction bits. Write the configuration registers only while no
// pixel is in flight.
`default_nettype none
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire pixel_word_t          pixel,
  output logic                      empty,
  input  wire logic                 pop,
  output result_word_t              result,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic front_valid;
  job_t front_job;
  logic q_full;
  logic q_empty;
  job_t q_job;
  logic q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_step         <= X_STEP_RST;
      cfg.y_step         <= Y_STEP_RST;
      cfg.x_origin       <= X_ORIGIN_RST;
      cfg.y_origin       <= Y_ORIGIN_RST;
      cfg.max_iterations <= MAX_ITER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_STEP:   cfg.x_step         <= cfg_data;
        REG_Y_STEP:   cfg.y_step         <= cfg_data;
        REG_X_ORIGIN: cfg.x_origin       <= cfg_data;
        REG_Y_ORIGIN: cfg.y_origin       <= cfg_data;
        REG_MAX_ITER: cfg.max_iterations <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .cfg       (cfg),
    .job_valid (front_valid),
    .job       (front_job),
    .job_ready (!q_full)
  );

  mbe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_job),
    .full  (q_full),
    .pop   (q_take),
    .dout  (q_job),
    .empty (q_empty)
  );

  mbe_iter u_iter (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (!q_empty),
    .job            (q_job),
    .job_take       (q_take),
    .max_iterations (cfg.max_iterations),
    .result_empty   (empty),
    .result         (result),
    .result_pop     (pop)
  );

endmodule
`default_nettype wire

FILE: hdl/mbe_checker.sv
`default_nettype none
module mbe_checker
  import mbe_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         push,
  input wire logic         full,
  input wire logic         empty,
  input wire logic         pop,
  input wire result_word_t result
);

  logic [31:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 32'(push && !full) - 32'(pop && !empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result word changed or vanished");

  a_color: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.color_index == color_of(result.escape_count)))
    else $error("color index does not match escape count");

  a_source: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != '0))
    else $error("result word without a pending pixel");

endmodule

bind mandelbrot_escape_time mbe_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
`default_nettype wire
